### hdl/mbet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multibrot escape-time package
// Shared widths, register indexes, datapath opcodes, the command and status
// structs between the controller and the datapath, and fixed-point helpers.
// ----------------------------------------------------------------------------
package mbet_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 28;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SHR_W     = PROD_W - FRAC_BITS;
    localparam int IDX_W     = 12;
    localparam int ITER_W    = 16;
    localparam int RAD_W     = 31;
    localparam int POW_W     = 4;
    localparam int COL_LIMIT = 4096;
    localparam int ROW_LIMIT = 4096;
    localparam int MAX_POWER = 8;
    localparam int PW_W      = $clog2(MAX_POWER + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_RE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_IM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER    = 3'd6;

    // Reset values of the configuration registers.
    localparam logic signed [DATA_W-1:0] RST_START_RE = -32'sd536870912;
    localparam logic signed [DATA_W-1:0] RST_START_IM = -32'sd402653184;
    localparam logic signed [DATA_W-1:0] RST_STEP_RE  = 32'sd196608;
    localparam logic signed [DATA_W-1:0] RST_STEP_IM  = 32'sd196608;
    localparam logic [ITER_W-1:0]        RST_MAX_ITER = 16'd256;
    localparam logic [RAD_W-1:0]         RST_RADIUS   = 31'd536870912;
    localparam logic [POW_W-1:0]         RST_POWER    = 4'd2;

    // Datapath opcodes. Each one selects the multiplier operands for this
    // cycle and the write-back of the product registered in the last cycle.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP = 4'd0;
    localparam logic [OP_W-1:0] OP_C0  = 4'd1;
    localparam logic [OP_W-1:0] OP_C1  = 4'd2;
    localparam logic [OP_W-1:0] OP_C2  = 4'd3;
    localparam logic [OP_W-1:0] OP_C3  = 4'd4;
    localparam logic [OP_W-1:0] OP_E0  = 4'd5;
    localparam logic [OP_W-1:0] OP_E1  = 4'd6;
    localparam logic [OP_W-1:0] OP_E2  = 4'd7;
    localparam logic [OP_W-1:0] OP_M0  = 4'd8;
    localparam logic [OP_W-1:0] OP_M1  = 4'd9;
    localparam logic [OP_W-1:0] OP_M2  = 4'd10;
    localparam logic [OP_W-1:0] OP_M3  = 4'd11;
    localparam logic [OP_W-1:0] OP_M4  = 4'd12;
    localparam logic [OP_W-1:0] OP_ADD = 4'd13;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            load_in;
        logic            load_out;
    } t_cmd;

    typedef struct packed {
        logic esc_now;
        logic at_limit;
    } t_sts;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(64'sd2147483647);
        lo = PROD_W'(-64'sd2147483648);
        if (v > hi) begin
            return hi[DATA_W-1:0];
        end else if (v < lo) begin
            return lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic [PW_W-1:0] clamp_power(input logic [POW_W-1:0] p);
        if (int'(p) < 2) begin
            return PW_W'(2);
        end else if (int'(p) > MAX_POWER) begin
            return PW_W'(MAX_POWER);
        end
        return PW_W'(p);
    endfunction

    function automatic logic [IDX_W-1:0] clamp_index(input logic [IDX_W-1:0] v,
                                                     input int limit);
        if (int'(v) > limit - 1) begin
            return IDX_W'(limit - 1);
        end
        return v;
    endfunction

endpackage

### hdl/mbet_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multibrot escape-time controller
// Sequences the shared multiplier through point forming, the escape test and
// the complex power loop, and owns both handshakes.
// ----------------------------------------------------------------------------
module mbet_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [mbet_pkg::POW_W-1:0]    i_power,
    input  mbet_pkg::t_sts                i_sts,
    output mbet_pkg::t_cmd                o_cmd
);
    import mbet_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_C0   = 4'd1;
    localparam logic [3:0] ST_C1   = 4'd2;
    localparam logic [3:0] ST_C2   = 4'd3;
    localparam logic [3:0] ST_C3   = 4'd4;
    localparam logic [3:0] ST_E0   = 4'd5;
    localparam logic [3:0] ST_E1   = 4'd6;
    localparam logic [3:0] ST_E2   = 4'd7;
    localparam logic [3:0] ST_M0   = 4'd8;
    localparam logic [3:0] ST_M1   = 4'd9;
    localparam logic [3:0] ST_M2   = 4'd10;
    localparam logic [3:0] ST_M3   = 4'd11;
    localparam logic [3:0] ST_M4   = 4'd12;
    localparam logic [3:0] ST_ADD  = 4'd13;
    localparam logic [3:0] ST_DONE = 4'd14;

    logic [3:0]      r_state, n_state;
    logic [PW_W-1:0] r_k, n_k;
    logic            r_out_valid, n_out_valid;
    logic [PW_W-1:0] w_pw;
    logic            w_out_free;

    assign w_pw       = clamp_power(i_power);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.op    = OP_NOP;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_C0;
                end
            end
            ST_C0: begin o_cmd.op = OP_C0; n_state = ST_C1; end
            ST_C1: begin o_cmd.op = OP_C1; n_state = ST_C2; end
            ST_C2: begin o_cmd.op = OP_C2; n_state = ST_C3; end
            ST_C3: begin o_cmd.op = OP_C3; n_state = ST_E0; end
            ST_E0: begin o_cmd.op = OP_E0; n_state = ST_E1; end
            ST_E1: begin o_cmd.op = OP_E1; n_state = ST_E2; end
            ST_E2: begin
                o_cmd.op = OP_E2;
                n_k      = PW_W'(1);
                if (i_sts.esc_now || i_sts.at_limit) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_M0;
                end
            end
            ST_M0: begin o_cmd.op = OP_M0; n_state = ST_M1; end
            ST_M1: begin o_cmd.op = OP_M1; n_state = ST_M2; end
            ST_M2: begin o_cmd.op = OP_M2; n_state = ST_M3; end
            ST_M3: begin o_cmd.op = OP_M3; n_state = ST_M4; end
            ST_M4: begin
                o_cmd.op = OP_M4;
                // One more complex product is needed until power-1 are done.
                if ((r_k + PW_W'(1)) < w_pw) begin
                    n_k     = r_k + PW_W'(1);
                    n_state = ST_M0;
                end else begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin o_cmd.op = OP_ADD; n_state = ST_E0; end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hdl/mbet_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multibrot escape-time datapath
// One registered 32x32 signed multiplier shared by every product, plus the
// saturating adders, the escape compare and the result registers.
// ----------------------------------------------------------------------------
module mbet_dp (
    input  logic                                 i_clk,
    input  mbet_pkg::t_cmd                       i_cmd,
    input  logic [mbet_pkg::IDX_W-1:0]           i_col,
    input  logic [mbet_pkg::IDX_W-1:0]           i_row,
    input  logic signed [mbet_pkg::DATA_W-1:0]   i_start_re,
    input  logic signed [mbet_pkg::DATA_W-1:0]   i_start_im,
    input  logic signed [mbet_pkg::DATA_W-1:0]   i_step_re,
    input  logic signed [mbet_pkg::DATA_W-1:0]   i_step_im,
    input  logic [mbet_pkg::ITER_W-1:0]          i_max_iter,
    input  logic [mbet_pkg::RAD_W-1:0]           i_escape_radius,
    output mbet_pkg::t_sts                       o_sts,
    output logic [mbet_pkg::ITER_W-1:0]          o_iterations,
    output logic signed [mbet_pkg::DATA_W-1:0]   o_final_re,
    output logic signed [mbet_pkg::DATA_W-1:0]   o_final_im,
    output logic                                 o_escaped
);
    import mbet_pkg::*;

    logic [IDX_W-1:0]          r_col, r_row;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [DATA_W-1:0]  r_cre, r_cim, r_zre, r_zim, r_pre, r_pim, r_nre;
    logic signed [SHR_W-1:0]   r_ta;
    logic [PROD_W-1:0]         r_r2;
    logic [PROD_W-2:0]         r_sq;
    logic [ITER_W-1:0]         r_n;
    logic                      r_esc;
    logic [ITER_W-1:0]         r_iterations;
    logic signed [DATA_W-1:0]  r_final_re, r_final_im;
    logic                      r_escaped;

    logic signed [DATA_W-1:0]  w_ma, w_mb;
    logic signed [SHR_W-1:0]   w_frac;
    logic [PROD_W-1:0]         w_mag;

    // Products are floored by the arithmetic shift.
    assign w_frac = SHR_W'(r_prod >>> FRAC_BITS);
    // Squares are never negative, so the sign bit of the product is dropped.
    assign w_mag  = PROD_W'(r_sq) + PROD_W'(r_prod[PROD_W-2:0]);

    assign o_sts.esc_now  = (w_mag >= r_r2);
    assign o_sts.at_limit = (r_n >= i_max_iter);

    always_comb begin
        w_ma = r_zre;
        w_mb = r_zre;
        case (i_cmd.op)
            OP_C0: begin w_ma = $signed(DATA_W'(r_col)); w_mb = i_step_re; end
            OP_C1: begin w_ma = $signed(DATA_W'(r_row)); w_mb = i_step_im; end
            OP_C2: begin
                w_ma = $signed(DATA_W'(i_escape_radius));
                w_mb = $signed(DATA_W'(i_escape_radius));
            end
            OP_E0: begin w_ma = r_zre; w_mb = r_zre; end
            OP_E1: begin w_ma = r_zim; w_mb = r_zim; end
            OP_M0: begin w_ma = r_pre; w_mb = r_zre; end
            OP_M1: begin w_ma = r_pim; w_mb = r_zim; end
            OP_M2: begin w_ma = r_pre; w_mb = r_zim; end
            OP_M3: begin w_ma = r_pim; w_mb = r_zre; end
            default: begin
                w_ma = r_zre;
                w_mb = r_zre;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (i_cmd.load_in) begin
            r_col <= clamp_index(i_col, COL_LIMIT);
            r_row <= clamp_index(i_row, ROW_LIMIT);
        end
        case (i_cmd.op)
            OP_C1: r_cre <= sat32(PROD_W'(i_start_re) + r_prod);
            OP_C2: r_cim <= sat32(PROD_W'(i_start_im) + r_prod);
            OP_C3: begin
                r_r2  <= r_prod;
                r_zre <= '0;
                r_zim <= '0;
                r_n   <= '0;
            end
            OP_E1: r_sq <= r_prod[PROD_W-2:0];
            OP_E2: begin
                r_esc <= o_sts.esc_now;
                r_pre <= r_zre;
                r_pim <= r_zim;
            end
            OP_M1: r_ta  <= w_frac;
            OP_M2: r_nre <= sat32(PROD_W'(r_ta) - PROD_W'(w_frac));
            OP_M3: r_ta  <= w_frac;
            OP_M4: begin
                r_pim <= sat32(PROD_W'(r_ta) + PROD_W'(w_frac));
                r_pre <= r_nre;
            end
            OP_ADD: begin
                r_zre <= sat32(PROD_W'(r_pre) + PROD_W'(r_cre));
                r_zim <= sat32(PROD_W'(r_pim) + PROD_W'(r_cim));
                r_n   <= r_n + ITER_W'(1);
            end
            default: begin
            end
        endcase
        if (i_cmd.load_out) begin
            r_iterations <= r_n;
            r_final_re   <= r_zre;
            r_final_im   <= r_zim;
            r_escaped    <= r_esc;
        end
    end

    assign o_iterations = r_iterations;
    assign o_final_re   = r_final_re;
    assign o_final_im   = r_final_im;
    assign o_escaped    = r_escaped;

endmodule

### hdl/multibrot_escape_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multibrot escape-time evaluator
// Iterates z = z^power + c in saturating Q4.28 for one pixel at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries a pixel column and row.
//   One pixel is worked on at a time; o_in_stall stays high from the
//   transaction until the result has moved into the output register.
//   Output channel (o_out_valid / i_out_stall) carries the iteration count,
//   the final z and the escaped flag. The output register holds its value
//   while i_out_stall is high; the next pixel is still accepted and computed
//   meanwhile, and waits finished until the output register frees up.
//   Every product goes through one shared 32x32 multiplier, so the steps run
//   in order: point forming and radius squaring (C0 to C3), then the escape
//   test (E0 to E2), and while the point has not escaped and the limit is not
//   reached, power - 1 complex products (M0 to M4 each) and the add of c (ADD)
//   before the next escape test; power is the clamped exponent.
//   Configuration writes (i_cfg_valid / o_cfg_ready) are always taken and
//   must only come while the block is idle.
//   Reset (synchronous, active low) returns the controller to idle, empties
//   the output register and loads the default view and limits.
// ----------------------------------------------------------------------------
module multibrot_escape_time (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [mbet_pkg::IDX_W-1:0]             i_col,
    input  logic [mbet_pkg::IDX_W-1:0]             i_row,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [mbet_pkg::ITER_W-1:0]            o_iterations,
    output logic signed [mbet_pkg::DATA_W-1:0]     o_final_re,
    output logic signed [mbet_pkg::DATA_W-1:0]     o_final_im,
    output logic                                   o_escaped,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mbet_pkg::DATA_W-1:0]            i_cfg_data
);
    import mbet_pkg::*;

    logic signed [DATA_W-1:0] r_start_re, r_start_im, r_step_re, r_step_im;
    logic [ITER_W-1:0]        r_max_iter;
    logic [RAD_W-1:0]         r_escape_radius;
    logic [POW_W-1:0]         r_power;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_re      <= RST_START_RE;
            r_start_im      <= RST_START_IM;
            r_step_re       <= RST_STEP_RE;
            r_step_im       <= RST_STEP_IM;
            r_max_iter      <= RST_MAX_ITER;
            r_escape_radius <= RST_RADIUS;
            r_power         <= RST_POWER;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_START_RE: r_start_re      <= $signed(i_cfg_data);
                CFG_START_IM: r_start_im      <= $signed(i_cfg_data);
                CFG_STEP_RE:  r_step_re       <= $signed(i_cfg_data);
                CFG_STEP_IM:  r_step_im       <= $signed(i_cfg_data);
                CFG_MAX_ITER: r_max_iter      <= i_cfg_data[ITER_W-1:0];
                CFG_RADIUS:   r_escape_radius <= i_cfg_data[RAD_W-1:0];
                CFG_POWER:    r_power         <= i_cfg_data[POW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mbet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_power     (r_power),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mbet_dp u_dp (
        .i_clk           (i_clk),
        .i_cmd           (w_cmd),
        .i_col           (i_col),
        .i_row           (i_row),
        .i_start_re      (r_start_re),
        .i_start_im      (r_start_im),
        .i_step_re       (r_step_re),
        .i_step_im       (r_step_im),
        .i_max_iter      (r_max_iter),
        .i_escape_radius (r_escape_radius),
        .o_sts           (w_sts),
        .o_iterations    (o_iterations),
        .o_final_re      (o_final_re),
        .o_final_im      (o_final_im),
        .o_escaped       (o_escaped)
    );

    // A result that did not escape must have run out of iterations.
    a_limit_when_not_escaped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_escaped) |-> (o_iterations == r_max_iter))
        else $error("non-escaped result below the iteration limit");

    a_iter_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_iterations <= r_max_iter))
        else $error("iteration count above the limit");

    // Only one pixel is in flight: a transaction closes the input at once.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input left open after a transaction");

endmodule
